// ===== hw/rtl/gpsp_pkg.sv =====
// Shared constants for the game pad serial poller.
package gpsp_pkg;

	localparam int unsigned GAP_TICKS_DEF = 2;

	localparam logic [7:0] CMD_START  = 8'h01;
	localparam logic [7:0] CMD_POLL   = 8'h42;
	localparam logic [7:0] HDR_OK     = 8'h5A;
	localparam logic [7:0] STICK_MID  = 8'h7F;
	localparam logic [7:0] SIGN_FLIP  = 8'h80;

	localparam logic [3:0] BYTE_START  = 4'd0;
	localparam logic [3:0] BYTE_POLL   = 4'd1;
	localparam logic [3:0] BYTE_HDR    = 4'd2;
	localparam logic [3:0] BYTE_FIRST  = 4'd3;
	localparam logic [3:0] BYTE_LAST   = 4'd8;

	localparam int unsigned REP_STORED = 5;

endpackage

// ===== hw/rtl/gpsp_stick.sv =====
// Stick dead zone and re-centring to a signed value.
module gpsp_stick (
	input  logic [7:0]        raw,
	input  logic [7:0]        dead_range,
	output logic signed [7:0] value
);
	import gpsp_pkg::*;

	logic [8:0] lo_sum;
	logic [8:0] hi_sum;
	logic       in_zone;
	logic [7:0] snapped;

	assign lo_sum  = {1'b0, raw} + {1'b0, dead_range};
	assign hi_sum  = {1'b0, STICK_MID} + {1'b0, dead_range};
	assign in_zone = (lo_sum > {1'b0, STICK_MID}) && (hi_sum > {1'b0, raw});
	assign snapped = in_zone ? STICK_MID : raw;
	assign value   = signed'(snapped ^ SIGN_FLIP);

endmodule

// ===== hw/rtl/game_pad_serial_poller_core.sv =====
// Top level of the game pad serial poller.
// The result for a tick is registered and appears on the master side in the cycle after the tick is accepted.
// Throughput: one tick per cycle; the slave side stalls only while a result waits unread.
// The line state machine advances once per accepted tick; its next-state logic is combinational.
// Reset clears the line state machine, counters, dead range and output valid.
// Stored report bytes are not reset; each is written before it is read.
module game_pad_serial_poller_core #(
	parameter int unsigned GAP_TICKS = gpsp_pkg::GAP_TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] data_bit, [1] poll_request, [7:2] zero
	input  logic [7:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] att_level, [1] clk_level, [2] cmd_level, [3] report_valid,
	// [19:4] buttons_pressed, [27:20] right_x, [35:28] right_y,
	// [43:36] left_x, [51:44] left_y, [55:52] zero
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import gpsp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ACTIVE,
		PH_GAP
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  byte_q, byte_n;
	logic [2:0]  bit_q, bit_n;
	logic        half_q, half_n;
	logic [7:0]  shift_q, shift_n;
	logic [7:0]  gap_q, gap_n;
	logic        retry_q, retry_n;
	logic [7:0]  dead_q;
	logic [7:0]  rep_q [REP_STORED];

	logic        rep_we;
	logic [2:0]  rep_idx;
	logic [7:0]  got;
	logic        att, clk_lvl, cmd, valid;
	logic [8:0]  gap_inc;
	logic        data_bit, poll_request, accept;

	logic signed [7:0] right_x, right_y, left_x, left_y;

	logic [55:0] res_d;
	logic        m_valid_q;
	logic [55:0] m_data_q;

	assign data_bit      = s_axis_tdata[0];
	assign poll_request  = s_axis_tdata[1];
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign gap_inc       = {1'b0, gap_q} + 9'd1;

	always_comb begin
		phase_n = phase_q;
		byte_n  = byte_q;
		bit_n   = bit_q;
		half_n  = half_q;
		shift_n = shift_q;
		gap_n   = gap_q;
		retry_n = retry_q;
		rep_we  = 1'b0;
		rep_idx = 3'd0;
		got     = 8'd0;
		att     = 1'b1;
		clk_lvl = 1'b1;
		cmd     = 1'b0;
		valid   = 1'b0;

		if (phase_q == PH_IDLE && poll_request) begin
			phase_n = PH_ACTIVE;
			byte_n  = BYTE_START;
			bit_n   = 3'd0;
			half_n  = 1'b0;
			shift_n = 8'd0;
			retry_n = 1'b0;
		end

		unique case (phase_n)
			PH_ACTIVE: begin
				att = 1'b0;
				if (byte_n == BYTE_START)
					cmd = CMD_START[bit_n];
				else if (byte_n == BYTE_POLL)
					cmd = CMD_POLL[bit_n];
				if (!half_n) begin
					clk_lvl = 1'b0;
					half_n  = 1'b1;
				end else begin
					half_n = 1'b0;
					if (byte_n >= BYTE_HDR)
						shift_n = shift_n | (8'(data_bit) << bit_n);
					if (bit_n == 3'd7) begin
						got     = shift_n;
						shift_n = 8'd0;
						bit_n   = 3'd0;
						if (byte_n == BYTE_HDR && got != HDR_OK) begin
							phase_n = PH_GAP;
							gap_n   = 8'd0;
							retry_n = 1'b1;
						end else if (byte_n >= BYTE_FIRST && byte_n < BYTE_LAST) begin
							rep_we  = 1'b1;
							rep_idx = 3'(byte_n - BYTE_FIRST);
						end else if (byte_n >= BYTE_LAST) begin
							valid   = (byte_n == BYTE_LAST);
							phase_n = PH_GAP;
							gap_n   = 8'd0;
							retry_n = 1'b0;
						end
						byte_n = byte_n + 4'd1;
					end else begin
						bit_n = bit_n + 3'd1;
					end
				end
			end
			PH_GAP: begin
				gap_n = gap_inc[7:0];
				if (gap_inc >= 9'(GAP_TICKS)) begin
					gap_n = 8'd0;
					if (retry_q) begin
						phase_n = PH_ACTIVE;
						byte_n  = BYTE_START;
						bit_n   = 3'd0;
						half_n  = 1'b0;
						shift_n = 8'd0;
						retry_n = 1'b0;
					end else begin
						phase_n = PH_IDLE;
					end
				end
			end
			default: ;
		endcase
	end

	gpsp_stick u_rx (.raw(rep_q[2]), .dead_range(dead_q), .value(right_x));
	gpsp_stick u_ry (.raw(rep_q[3]), .dead_range(dead_q), .value(right_y));
	gpsp_stick u_lx (.raw(rep_q[4]), .dead_range(dead_q), .value(left_x));
	gpsp_stick u_ly (.raw(got),      .dead_range(dead_q), .value(left_y));

	always_comb begin
		res_d    = '0;
		res_d[0] = att;
		res_d[1] = clk_lvl;
		res_d[2] = cmd;
		res_d[3] = valid;
		if (valid) begin
			res_d[19:4]  = {~rep_q[1], ~rep_q[0]};
			res_d[27:20] = right_x;
			res_d[35:28] = right_y;
			res_d[43:36] = left_x;
			res_d[51:44] = left_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			byte_q    <= 4'd0;
			bit_q     <= 3'd0;
			half_q    <= 1'b0;
			shift_q   <= 8'd0;
			gap_q     <= 8'd0;
			retry_q   <= 1'b0;
			dead_q    <= 8'd0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				dead_q <= cfg_wdata;
			if (accept) begin
				phase_q <= phase_n;
				byte_q  <= byte_n;
				bit_q   <= bit_n;
				half_q  <= half_n;
				shift_q <= shift_n;
				gap_q   <= gap_n;
				retry_q <= retry_n;
			end
			if (accept)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && rep_we)
			rep_q[rep_idx] <= got;
		if (accept)
			m_data_q <= res_d;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_report_framing: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[3] |-> !m_data_q[0] && m_data_q[1])
		else $error("report issued outside an active clock-high tick");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_axis_tready |=> m_valid_q && $stable(m_data_q))
		else $error("pending result overwritten");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_GAP |-> {1'b0, gap_q} < 9'(GAP_TICKS))
		else $error("gap counter beyond gap length");

	a_byte_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ACTIVE |-> byte_q <= BYTE_LAST)
		else $error("byte index beyond last report byte");

	a_retry_only_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		retry_q |-> phase_q == PH_GAP)
		else $error("retry pending outside gap");

endmodule
